@@ hw/rtl/dtsb_pkg.sv @@
package dtsb_pkg;

  // layout codes held in the format register
  localparam logic [2:0] FMT_1541 = 3'd0;
  localparam logic [2:0] FMT_1571 = 3'd1;
  localparam logic [2:0] FMT_1581 = 3'd2;
  localparam logic [2:0] FMT_8050 = 3'd3;
  localparam logic [2:0] FMT_8250 = 3'd4;

  localparam logic [7:0]  TRACKS_1541_SIDE    = 8'd35;
  localparam logic [7:0]  LAST_TRACK_ZONED    = 8'd42;
  localparam logic [7:0]  LAST_TRACK_ZONED_DS = 8'd70;
  localparam logic [7:0]  LAST_TRACK_FLAT     = 8'd80;
  localparam logic [7:0]  TRACKS_8050_SIDE    = 8'd77;
  localparam logic [7:0]  LAST_TRACK_WIDE_DS  = 8'd154;
  localparam logic [11:0] BLOCKS_1541_SIDE    = 12'd683;
  localparam logic [11:0] BLOCKS_8050_SIDE    = 12'd2083;
  localparam logic [5:0]  SECTORS_1581        = 6'd40;
  localparam logic [12:0] MAX_BLOCK           = 13'd4165;

  typedef struct packed {
    logic [7:0] track;
    logic [7:0] sector;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [12:0] block_index;
  } out_t;

  // after decode: side folded, track range checked
  typedef struct packed {
    logic        vld;
    logic [2:0]  fmt;
    logic        trk_ok;
    logic [6:0]  ltrk;
    logic [7:0]  sector;
    logic [11:0] base;
  } dec_t;

  // after lookup: start of track known, sector checked
  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [11:0] start;
    logic [7:0]  sector;
    logic [11:0] base;
  } lkp_t;

  function automatic logic [5:0] spt_c1541(input logic [6:0] t);
    logic [5:0] s;
    if (t <= 7'd17)      s = 6'd21;
    else if (t <= 7'd24) s = 6'd19;
    else if (t <= 7'd30) s = 6'd18;
    else                 s = 6'd17;
    return s;
  endfunction

  function automatic logic [11:0] start_c1541(input logic [6:0] t);
    logic [11:0] n;
    logic [11:0] s;
    n = {5'd0, t} - 12'd1;
    if (n <= 12'd17)      s = 12'd21 * n;
    else if (n <= 12'd24) s = 12'd357 + 12'd19 * (n - 12'd17);
    else if (n <= 12'd30) s = 12'd490 + 12'd18 * (n - 12'd24);
    else                  s = 12'd598 + 12'd17 * (n - 12'd30);
    return s;
  endfunction

  function automatic logic [5:0] spt_c8050(input logic [6:0] t);
    logic [5:0] s;
    if (t <= 7'd39)      s = 6'd29;
    else if (t <= 7'd53) s = 6'd27;
    else if (t <= 7'd64) s = 6'd25;
    else                 s = 6'd23;
    return s;
  endfunction

  function automatic logic [11:0] start_c8050(input logic [6:0] t);
    logic [11:0] n;
    logic [11:0] s;
    n = {5'd0, t} - 12'd1;
    if (n <= 12'd39)      s = 12'd29 * n;
    else if (n <= 12'd53) s = 12'd1131 + 12'd27 * (n - 12'd39);
    else if (n <= 12'd64) s = 12'd1509 + 12'd25 * (n - 12'd53);
    else                  s = 12'd1784 + 12'd23 * (n - 12'd64);
    return s;
  endfunction

endpackage

@@ hw/rtl/dtsb_decode.sv @@
module dtsb_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  dtsb_pkg::in_t     item,
  input  logic [2:0]        fmt,
  output dtsb_pkg::dec_t    dec
);
  import dtsb_pkg::*;

  logic       vld_r;
  dec_t       pay_r;
  dec_t       pay_nxt;
  logic [7:0] t;

  always_comb begin
    t = item.track;
    pay_nxt        = '0;
    pay_nxt.fmt    = fmt;
    pay_nxt.sector = item.sector;
    pay_nxt.ltrk   = t[6:0];
    pay_nxt.base   = 12'd0;
    case (fmt)
      FMT_1541: pay_nxt.trk_ok = (t != 8'd0) && (t <= LAST_TRACK_ZONED);
      FMT_1571: begin
        pay_nxt.trk_ok = (t != 8'd0) && (t <= LAST_TRACK_ZONED_DS);
        if (t > TRACKS_1541_SIDE) begin
          pay_nxt.ltrk = 7'(t - TRACKS_1541_SIDE);
          pay_nxt.base = BLOCKS_1541_SIDE;
        end
      end
      FMT_1581: pay_nxt.trk_ok = (t != 8'd0) && (t <= LAST_TRACK_FLAT);
      FMT_8050: pay_nxt.trk_ok = (t != 8'd0) && (t <= TRACKS_8050_SIDE);
      FMT_8250: begin
        pay_nxt.trk_ok = (t != 8'd0) && (t <= LAST_TRACK_WIDE_DS);
        if (t > TRACKS_8050_SIDE) begin
          pay_nxt.ltrk = 7'(t - TRACKS_8050_SIDE);
          pay_nxt.base = BLOCKS_8050_SIDE;
        end
      end
      default: pay_nxt.trk_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pay_r <= pay_nxt;
    end
  end

  always_comb begin
    dec     = pay_r;
    dec.vld = vld_r;
  end

endmodule

@@ hw/rtl/dtsb_lookup.sv @@
module dtsb_lookup (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsb_pkg::dec_t  dec,
  output dtsb_pkg::lkp_t  lkp
);
  import dtsb_pkg::*;

  logic       vld_r;
  lkp_t       pay_r;
  lkp_t       pay_nxt;
  logic [5:0] spt;

  always_comb begin
    pay_nxt        = '0;
    pay_nxt.sector = dec.sector;
    pay_nxt.base   = dec.base;
    case (dec.fmt)
      FMT_1541, FMT_1571: begin
        spt           = spt_c1541(dec.ltrk);
        pay_nxt.start = start_c1541(dec.ltrk);
      end
      FMT_1581: begin
        spt           = SECTORS_1581;
        pay_nxt.start = 12'(({5'd0, dec.ltrk} - 12'd1) * 12'd40);
      end
      FMT_8050, FMT_8250: begin
        spt           = spt_c8050(dec.ltrk);
        pay_nxt.start = start_c8050(dec.ltrk);
      end
      default: begin
        spt           = 6'd0;
        pay_nxt.start = 12'd0;
      end
    endcase
    pay_nxt.ok = dec.trk_ok && (dec.sector < {2'b00, spt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= dec.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.vld) begin
      pay_r <= pay_nxt;
    end
  end

  always_comb begin
    lkp     = pay_r;
    lkp.vld = vld_r;
  end

endmodule

@@ hw/rtl/dtsb_sum.sv @@
module dtsb_sum (
  input  logic            clk,
  input  logic            rst_n,
  input  dtsb_pkg::lkp_t  lkp,
  output logic            strobe,
  output dtsb_pkg::out_t  res
);
  import dtsb_pkg::*;

  logic        strobe_r;
  out_t        res_r;
  out_t        res_nxt;
  logic [12:0] blk;

  always_comb begin
    blk = {1'b0, lkp.base} + {1'b0, lkp.start} + {5'd0, lkp.sector};
    res_nxt.valid_res   = lkp.ok;
    res_nxt.block_index = lkp.ok ? blk : 13'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= lkp.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (lkp.vld) begin
      res_r <= res_nxt;
    end
  end

  assign strobe = strobe_r;
  assign res    = res_r;

endmodule

@@ hw/rtl/disk_track_sector_to_block.sv @@
// disk track/sector to linear block translator
//
// in channel: drive in_item (track, sector) and pulse start; the item is
// taken at a clock edge where start is high and busy is low. busy is only
// high in reset and for the first cycle out of reset, so a new item may be
// started on every clock: throughput is one item per cycle.
// out channel: once the item is through the decode, lookup and sum registers,
// out_strobe is high for exactly one cycle with out_res (valid_res,
// block_index). results come out in the order items went in. the receiver
// cannot stall the block and must take each result in the cycle it is shown.
// the item passes three register stages: side fold and track check,
// zone table lookup, then the final add of side base, track start and sector.
// cfg channel: cfg_we writes cfg_wdata into the format register; write it
// only while no item is in flight.
// reset (synchronous, active low) clears all stage valid bits, drops any
// item in flight and sets the format to the single-sided zoned layout.
module disk_track_sector_to_block (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dtsb_pkg::in_t   in_item,
  output logic            out_strobe,
  output dtsb_pkg::out_t  out_res,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_wdata
);
  import dtsb_pkg::*;

  logic       busy_r;
  logic [2:0] fmt_r;
  logic       accept;
  dec_t       dec;
  lkp_t       lkp;

  // busy covers reset and the cycle right after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_1541;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // stage 1: fold second side onto first side zones, check track range
  dtsb_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .fmt    (fmt_r),
    .dec    (dec)
  );

  // stage 2: start-of-track and sectors-per-track lookup
  dtsb_lookup u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .dec   (dec),
    .lkp   (lkp)
  );

  // stage 3: final add and result register
  dtsb_sum u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .lkp    (lkp),
    .strobe (out_strobe),
    .res    (out_res)
  );

  // every accepted item comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) |-> out_strobe)
    else $error("accepted item did not produce a result");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 3))
    else $error("result without an accepted item");

  // rejected requests report block zero
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.valid_res |-> out_res.block_index == 13'd0)
    else $error("invalid result with nonzero block index");

  // block index stays inside the largest layout
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_res.block_index <= MAX_BLOCK)
    else $error("block index out of range");

  // busy drops in the cycle after reset is released and stays low
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset recovery");

endmodule
